// File: hdl/assert_macros.svh
// Assertion macros shared by the address region table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain invariant, checked at every clock edge outside reset.
`define SART_ASSERT(lbl, clk_s, rst_s, expr, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (expr)) else $error(msg);

// Same-cycle implication.
`define SART_IMPLY(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SART_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/sart_pkg.sv
// Shared types and codes of the sorted address region table.
`default_nettype none

package sart_pkg;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVAL    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  localparam logic [1:0] REQ_LOOKUP = 2'd0;
  localparam logic [1:0] REQ_ADD    = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  typedef struct packed {
    logic    valid;
    status_t status;
  } rsp_ctl_t;

endpackage

`default_nettype wire

// File: hdl/sorted_address_region_table.sv
// Top level of the sorted address region table with its output register.
`default_nettype none
`include "assert_macros.svh"

// The block keeps up to MAX_REGIONS non-overlapping address regions, sorted by
// start page, in one synchronous memory. Each request beat is a lookup, an add
// or a remove and produces exactly one result beat; any other request type is
// answered as invalid. The block works on one request at a time: after a beat
// is accepted it walks the stored entries one per cycle through the memory's
// single read port. A successful add or remove then moves the entries above
// the insertion or removal point one slot per cycle, read and written back
// through the same memory. The result sits in an output register, so the next
// request beat can be taken while a finished result still waits on out_stall.
// A result whose status is not success carries zero in all region fields. The
// memory needs no clearing after reset, since only entries below the stored
// count are ever read.
module sorted_address_region_table #(
  parameter int MAX_REGIONS = 16,
  parameter int PAGE_SHIFT  = 12
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         req_type,
  input  wire logic [31:0]        addr,
  input  wire logic [31:0]        end_addr,
  input  wire logic [7:0]         access_flags,
  input  wire logic [7:0]         map_flags,
  input  wire logic [15:0]        file_handle,
  input  wire logic signed [31:0] backing_offset,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              status,
  output logic [31:0]             region_start,
  output logic [31:0]             region_end,
  output logic [7:0]              region_access,
  output logic [7:0]              region_map,
  output logic [15:0]             region_file,
  output logic signed [31:0]      region_offset
);

  import sart_pkg::*;

  localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int PW = 32 - PAGE_SHIFT;
  localparam int RW = 2 * PW + 64;

  typedef struct packed {
    logic [PW-1:0] spage;
    logic [PW-1:0] epage;
    logic [7:0]    acc;
    logic [7:0]    mapf;
    logic [15:0]   file;
    logic [31:0]   off;
  } rec_t;

  rsp_ctl_t      rsp;
  logic [RW-1:0] rsp_rec;
  rec_t          rec;
  logic          rsp_ready;
  logic          ok;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [RW-1:0] mem_wdata;
  logic [IW-1:0] mem_raddr;
  logic [RW-1:0] mem_rdata;
  logic          fields_zero;

  sart_ctrl #(
    .MAX_REGIONS (MAX_REGIONS),
    .PAGE_SHIFT  (PAGE_SHIFT)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .req_type       (req_type),
    .addr           (addr),
    .end_addr       (end_addr),
    .access_flags   (access_flags),
    .map_flags      (map_flags),
    .file_handle    (file_handle),
    .backing_offset (backing_offset),
    .rsp            (rsp),
    .rsp_rec        (rsp_rec),
    .rsp_ready      (rsp_ready),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .mem_raddr      (mem_raddr),
    .mem_rdata      (mem_rdata)
  );

  sart_ram #(
    .W  (RW),
    .D  (MAX_REGIONS),
    .AW (IW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // The output register can take a new result when it is empty or when its
  // current beat leaves in this cycle.
  assign rsp_ready = !out_valid || !out_stall;
  assign rec       = rsp_rec;
  assign ok        = rsp.status == ST_OK;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rsp.valid && rsp_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Failed requests report zero in every region field.
  always_ff @(posedge clk) begin
    if (rsp.valid && rsp_ready) begin
      status        <= rsp.status;
      region_start  <= ok ? {rec.spage, {PAGE_SHIFT{1'b0}}} : '0;
      region_end    <= ok ? {rec.epage, {PAGE_SHIFT{1'b0}}} : '0;
      region_access <= ok ? rec.acc : '0;
      region_map    <= ok ? rec.mapf : '0;
      region_file   <= ok ? rec.file : '0;
      region_offset <= ok ? rec.off : '0;
    end
  end

  assign fields_zero = region_start == '0 && region_end == '0 && region_access == '0
                    && region_map == '0 && region_file == '0 && region_offset == '0;

  `SART_NEXT(a_rsp_load, clk, rst, rsp.valid && rsp_ready, out_valid, "result not registered")
  `SART_IMPLY(a_fail_zero, clk, rst, out_valid && status != ST_OK, fields_zero, "failed result not zero")

endmodule

`default_nettype wire

// File: hdl/sart_ram.sv
// Region entry memory: one write port, one registered read port.
`default_nettype none

module sart_ram #(
  parameter int W  = 104,
  parameter int D  = 16,
  parameter int AW = 4
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hdl/sart_ctrl.sv
// Request sequencer: scans, shifts and inserts entries in the region memory.
`default_nettype none
`include "assert_macros.svh"

module sart_ctrl #(
  parameter int MAX_REGIONS = 16,
  parameter int PAGE_SHIFT  = 12,
  localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1,
  localparam int CW = $clog2(MAX_REGIONS + 1),
  localparam int PW = 32 - PAGE_SHIFT,
  localparam int RW = 2 * PW + 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         req_type,
  input  wire logic [31:0]        addr,
  input  wire logic [31:0]        end_addr,
  input  wire logic [7:0]         access_flags,
  input  wire logic [7:0]         map_flags,
  input  wire logic [15:0]        file_handle,
  input  wire logic signed [31:0] backing_offset,
  output sart_pkg::rsp_ctl_t      rsp,
  output logic [RW-1:0]           rsp_rec,
  input  wire logic               rsp_ready,
  output logic                    mem_we,
  output logic [IW-1:0]           mem_waddr,
  output logic [RW-1:0]           mem_wdata,
  output logic [IW-1:0]           mem_raddr,
  input  wire logic [RW-1:0]      mem_rdata
);

  import sart_pkg::*;

  typedef struct packed {
    logic [PW-1:0] spage;
    logic [PW-1:0] epage;
    logic [7:0]    acc;
    logic [7:0]    mapf;
    logic [15:0]   file;
    logic [31:0]   off;
  } rec_t;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_SHIFT  = 5'b00100,
    S_INSERT = 5'b01000,
    S_RESP   = 5'b10000
  } state_t;

  state_t        state;
  logic [CW-1:0] count;
  logic [1:0]    req;
  logic [PW-1:0] sp;
  logic [PW-1:0] ep;
  logic          bad;
  logic [7:0]    acc;
  logic [7:0]    mapf;
  logic [15:0]   file;
  logic [31:0]   off;
  logic [CW-1:0] rd_ptr;
  logic [CW-1:0] rd_dec;
  logic          chk_vld;
  logic [CW-1:0] chk_idx;
  logic          found;
  logic          overlap;
  logic [CW-1:0] pos;
  logic [CW-1:0] hit_idx;
  rec_t          hit_rec;
  status_t       status;
  logic          shift_up;
  logic          issue;
  logic [32:0]   end_sum;
  logic [31:0]   ofs_u;
  logic [31:0]   off_in;
  rec_t          r;
  rec_t          new_rec;
  logic [CW-1:0] dst_idx;
  logic          upd_state;

  assign end_sum = {1'b0, end_addr} + {{(33 - PAGE_SHIFT){1'b0}}, {PAGE_SHIFT{1'b1}}};
  assign ofs_u   = backing_offset;
  assign off_in  = (file_handle != 16'd0)
                 ? ofs_u - {{(32 - PAGE_SHIFT){1'b0}}, addr[PAGE_SHIFT-1:0]}
                 : ofs_u;

  assign r      = mem_rdata;
  assign rd_dec = rd_ptr - 1'b1;

  always_comb begin
    new_rec.spage = sp;
    new_rec.epage = ep;
    new_rec.acc   = acc;
    new_rec.mapf  = mapf;
    new_rec.file  = file;
    new_rec.off   = off;
  end

  always_comb begin
    issue = 1'b0;
    if (state == S_SCAN) begin
      issue = rd_ptr < count;
    end else if (state == S_SHIFT) begin
      issue = shift_up ? (rd_ptr > pos) : (rd_ptr < count);
    end
  end

  assign mem_raddr = (state == S_SHIFT && shift_up) ? rd_dec[IW-1:0] : rd_ptr[IW-1:0];

  always_comb begin
    dst_idx = shift_up ? chk_idx + 1'b1 : chk_idx - 1'b1;
    if (state == S_INSERT) begin
      dst_idx = pos;
    end
  end

  assign mem_we    = (state == S_SHIFT && chk_vld) || state == S_INSERT;
  assign mem_waddr = dst_idx[IW-1:0];
  assign mem_wdata = (state == S_INSERT) ? new_rec : mem_rdata;

  assign in_stall     = state != S_IDLE;
  assign rsp.valid    = state == S_RESP;
  assign rsp.status   = status;
  assign rsp_rec      = hit_rec;

  // Only the shift and insert states may touch the memory or the count.
  assign upd_state = (state == S_SHIFT) || (state == S_INSERT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      chk_vld <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          chk_vld <= 1'b0;
          if (in_valid) begin
            req     <= req_type;
            sp      <= addr[31:PAGE_SHIFT];
            ep      <= end_sum[31:PAGE_SHIFT];
            bad     <= (addr >= end_addr) || end_sum[32];
            acc     <= access_flags;
            mapf    <= map_flags;
            file    <= file_handle;
            off     <= off_in;
            rd_ptr  <= '0;
            found   <= 1'b0;
            overlap <= 1'b0;
            pos     <= '0;
            state   <= S_SCAN;
          end
        end
        S_SCAN: begin
          chk_vld <= issue;
          chk_idx <= rd_ptr;
          if (issue) begin
            rd_ptr <= rd_ptr + 1'b1;
          end
          if (chk_vld) begin
            if (sp >= r.spage && sp < r.epage && !found) begin
              found   <= 1'b1;
              hit_idx <= chk_idx;
              hit_rec <= r;
            end
            if (sp < r.epage && ep > r.spage) begin
              overlap <= 1'b1;
            end
            if (r.spage < sp) begin
              pos <= chk_idx + 1'b1;
            end
          end
          if (!issue && !chk_vld) begin
            unique case (req)
              REQ_LOOKUP: begin
                status <= found ? ST_OK : ST_NOTFOUND;
                state  <= S_RESP;
              end
              REQ_REMOVE: begin
                if (found) begin
                  status   <= ST_OK;
                  shift_up <= 1'b0;
                  rd_ptr   <= hit_idx + 1'b1;
                  state    <= S_SHIFT;
                end else begin
                  status <= ST_NOTFOUND;
                  state  <= S_RESP;
                end
              end
              REQ_ADD: begin
                if (bad || overlap) begin
                  status <= ST_INVAL;
                  state  <= S_RESP;
                end else if (count == CW'(MAX_REGIONS)) begin
                  status <= ST_FULL;
                  state  <= S_RESP;
                end else begin
                  status   <= ST_OK;
                  shift_up <= 1'b1;
                  rd_ptr   <= count;
                  state    <= S_SHIFT;
                end
              end
              default: begin
                status <= ST_INVAL;
                state  <= S_RESP;
              end
            endcase
          end
        end
        S_SHIFT: begin
          chk_vld <= issue;
          if (issue) begin
            if (shift_up) begin
              rd_ptr  <= rd_dec;
              chk_idx <= rd_dec;
            end else begin
              rd_ptr  <= rd_ptr + 1'b1;
              chk_idx <= rd_ptr;
            end
          end
          if (!issue && !chk_vld) begin
            if (shift_up) begin
              state <= S_INSERT;
            end else begin
              count <= count - 1'b1;
              state <= S_RESP;
            end
          end
        end
        S_INSERT: begin
          hit_rec <= new_rec;
          count   <= count + 1'b1;
          state   <= S_RESP;
        end
        S_RESP: begin
          if (rsp_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `SART_ASSERT(a_count_max, clk, rst, count <= CW'(MAX_REGIONS), "entry count above capacity")
  `SART_IMPLY(a_we_state, clk, rst, mem_we, upd_state, "stray write")
  `SART_NEXT(a_count_hold, clk, rst, !upd_state, $stable(count), "count moved outside an update")

endmodule

`default_nettype wire
